@@ rtl/q2e_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table for the
// quaternion to Euler angle converter. No dependencies.
package q2e_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int STEPS        = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

   localparam int VW = 38;       // CORDIC vector width, Q28 plus gain headroom
   localparam int AW = 32;       // angle accumulator, 1/65536 of 0.01 degree
   localparam int RW = 58;       // square root remainder width
   localparam int SQ_STEPS = 29; // one result bit per stage

   localparam int FRONT_LAT  = 3;
   localparam int CORDIC_LAT = STEPS + 1;
   localparam int LATENCY    = FRONT_LAT + SQ_STEPS + CORDIC_LAT + 1;

   localparam logic signed [VW-1:0] ONE_Q28      = VW'(64'sd268435456);
   localparam logic signed [AW-1:0] QUARTER_TURN = AW'(64'sd589824000);

   typedef logic signed [VW-1:0] vec_type;
   typedef logic signed [16:0]   angle_type;

   typedef struct packed {
      vec_type pitch_s;
      vec_type yaw_y;
      vec_type yaw_x;
      vec_type roll_y;
      vec_type roll_x;
   } side_type;

   function automatic logic [29:0] atan_entry(input int idx);
      logic [29:0] r;
      case (idx)
         0:  r = 30'd294912000;
         1:  r = 30'd174096719;
         2:  r = 30'd91987925;
         3:  r = 30'd46694507;
         4:  r = 30'd23437865;
         5:  r = 30'd11730358;
         6:  r = 30'd5866610;
         7:  r = 30'd2933484;
         8:  r = 30'd1466764;
         9:  r = 30'd733385;
         10: r = 30'd366693;
         11: r = 30'd183346;
         12: r = 30'd91673;
         13: r = 30'd45837;
         14: r = 30'd22918;
         15: r = 30'd11459;
         16: r = 30'd5730;
         17: r = 30'd2865;
         18: r = 30'd1432;
         19: r = 30'd716;
         20: r = 30'd358;
         21: r = 30'd179;
         22: r = 30'd90;
         23: r = 30'd45;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/quaternion_to_euler_degrees.sv @@
// Quaternion to pitch/yaw/roll in 0.01 degree. Fully pipelined: one request
// per cycle, busy is always low. The pipeline holds 3 product/sum/square
// stages, 29 square-root stages, the CORDIC pre-rotation plus one stage per
// step, and the output clamp register.
// Reset clears only the valid bits; results are never held off by the receiver.
module quaternion_to_euler_degrees
   import q2e_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_yaw_angle,
   output logic signed [15:0] rsp_roll_angle
);

   logic        f_valid, q_valid, p_valid, y_valid, r_valid;
   logic [56:0] f_s2;
   side_type    f_side, q_side;
   vec_type     q_root;
   angle_type   p_ang, y_ang, r_ang;
   logic        valid_ff;
   logic signed [14:0] pitch_ff, pitch_in;
   logic signed [15:0] yaw_ff, yaw_in, roll_ff, roll_in;

   assign busy = 1'b0;

   q2e_front u_front (
      .clock, .reset,
      .in_valid (start),
      .in_w     (req_quat_w),
      .in_x     (req_quat_x),
      .in_y     (req_quat_y),
      .in_z     (req_quat_z),
      .out_valid(f_valid),
      .out_s2   (f_s2),
      .out_side (f_side)
   );

   q2e_isqrt u_isqrt (
      .clock, .reset,
      .in_valid (f_valid),
      .in_s2    (f_s2),
      .in_side  (f_side),
      .out_valid(q_valid),
      .out_root (q_root),
      .out_side (q_side)
   );

   q2e_cordic u_pitch (
      .clock, .reset,
      .in_valid (q_valid),
      .in_y     (q_side.pitch_s),
      .in_x     (q_root),
      .out_valid(p_valid),
      .out_angle(p_ang)
   );

   q2e_cordic u_yaw (
      .clock, .reset,
      .in_valid (q_valid),
      .in_y     (q_side.yaw_y),
      .in_x     (q_side.yaw_x),
      .out_valid(y_valid),
      .out_angle(y_ang)
   );

   q2e_cordic u_roll (
      .clock, .reset,
      .in_valid (q_valid),
      .in_y     (q_side.roll_y),
      .in_x     (q_side.roll_x),
      .out_valid(r_valid),
      .out_angle(r_ang)
   );

   always_comb begin
      pitch_in = p_ang[14:0];
      if (p_ang > 17'sd9000) begin
         pitch_in = 15'sd9000;
      end else if (p_ang < -17'sd9000) begin
         pitch_in = -15'sd9000;
      end
      yaw_in = y_ang[15:0];
      if (y_ang > 17'sd18000) begin
         yaw_in = 16'sd18000;
      end else if (y_ang < -17'sd18000) begin
         yaw_in = -16'sd18000;
      end
      roll_in = r_ang[15:0];
      if (r_ang > 17'sd18000) begin
         roll_in = 16'sd18000;
      end else if (r_ang < -17'sd18000) begin
         roll_in = -16'sd18000;
      end
   end

   always_ff @(posedge clock) begin
      pitch_ff <= pitch_in;
      yaw_ff   <= yaw_in;
      roll_ff  <= roll_in;
   end

   // all three CORDICs share one latency
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= p_valid & y_valid & r_valid;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_yaw_angle   = yaw_ff;
   assign rsp_roll_angle  = roll_ff;

endmodule

@@ rtl/q2e_front.sv @@
// Front end: component products, sums with pitch argument saturation,
// and the square of the pitch argument. Three register stages. Uses q2e_pkg.
module q2e_front
   import q2e_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [15:0] in_w,
   input  logic signed [15:0] in_x,
   input  logic signed [15:0] in_y,
   input  logic signed [15:0] in_z,
   output logic               out_valid,
   output logic [56:0]        out_s2,
   output side_type           out_side
);

   logic signed [31:0] wx_ff, yz_ff, wy_ff, zx_ff, wz_ff, xy_ff, xx_ff, yy_ff, zz_ff;
   logic [2:0]         valid_ff;
   side_type           side2_ff, side3_ff, side2_in;
   logic [56:0]        s2_ff;
   vec_type            s_raw, s_abs;

   always_ff @(posedge clock) begin
      wx_ff <= in_w * in_x;
      yz_ff <= in_y * in_z;
      wy_ff <= in_w * in_y;
      zx_ff <= in_z * in_x;
      wz_ff <= in_w * in_z;
      xy_ff <= in_x * in_y;
      xx_ff <= in_x * in_x;
      yy_ff <= in_y * in_y;
      zz_ff <= in_z * in_z;
   end

   always_comb begin
      s_raw = (VW'(wx_ff) - VW'(yz_ff)) <<< 1;
      side2_in.pitch_s = s_raw;
      if (s_raw > ONE_Q28) begin
         side2_in.pitch_s = ONE_Q28;
      end else if (s_raw < -ONE_Q28) begin
         side2_in.pitch_s = -ONE_Q28;
      end
      side2_in.yaw_y  = (VW'(wy_ff) + VW'(zx_ff)) <<< 1;
      side2_in.yaw_x  = ONE_Q28 - ((VW'(xx_ff) + VW'(yy_ff)) <<< 1);
      side2_in.roll_y = (VW'(wz_ff) + VW'(xy_ff)) <<< 1;
      side2_in.roll_x = ONE_Q28 - ((VW'(xx_ff) + VW'(zz_ff)) <<< 1);
   end

   assign s_abs = side2_ff.pitch_s[VW-1] ? -side2_ff.pitch_s : side2_ff.pitch_s;

   always_ff @(posedge clock) begin
      side2_ff <= side2_in;
      side3_ff <= side2_ff;
      s2_ff    <= 57'({28'd0, s_abs[28:0]} * {28'd0, s_abs[28:0]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   assign out_valid = valid_ff[2];
   assign out_s2    = s2_ff;
   assign out_side  = side3_ff;

endmodule

@@ rtl/q2e_isqrt.sv @@
// Pipelined integer square root of 2^56 - s^2, one result bit per stage,
// with the angle vectors carried alongside. Uses q2e_pkg.
module q2e_isqrt
   import q2e_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [56:0] in_s2,
   input  side_type    in_side,
   output logic        out_valid,
   output vec_type     out_root,
   output side_type    out_side
);

   logic [RW-1:0] rem_ff  [0:SQ_STEPS-1];
   logic [RW-1:0] root_ff [0:SQ_STEPS-1];
   side_type      side_ff [0:SQ_STEPS-1];
   logic [SQ_STEPS-1:0] valid_ff;

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
      localparam logic [RW-1:0] BITV = RW'(1) << (56 - 2 * k);
      logic [RW-1:0] rem_cur, root_cur, trial, rem_in, root_in;
      side_type      side_cur;

      if (k == 0) begin : g_first
         assign rem_cur  = (RW'(1) << 56) - RW'(in_s2);
         assign root_cur = '0;
         assign side_cur = in_side;
      end else begin : g_next
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
         assign side_cur = side_ff[k-1];
      end

      always_comb begin
         trial = root_cur + BITV;
         if (rem_cur >= trial) begin
            rem_in  = rem_cur - trial;
            root_in = (root_cur >> 1) + BITV;
         end else begin
            rem_in  = rem_cur;
            root_in = root_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         side_ff[k] <= side_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[SQ_STEPS-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[SQ_STEPS-1];
   assign out_root  = VW'({1'b0, root_ff[SQ_STEPS-1][28:0]});
   assign out_side  = side_ff[SQ_STEPS-1];

endmodule

@@ rtl/q2e_cordic.sv @@
// Pipelined vectoring CORDIC arctangent: a half-plane pre-rotation stage,
// then one micro-rotation per stage. Angle out in 0.01 degree. Uses q2e_pkg.
module q2e_cordic
   import q2e_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  vec_type   in_y,
   input  vec_type   in_x,
   output logic      out_valid,
   output angle_type out_angle
);

   vec_type          x_ff   [0:STEPS];
   vec_type          y_ff   [0:STEPS];
   logic signed [AW-1:0] acc_ff [0:STEPS];
   logic [STEPS:0]   zero_ff;
   logic [STEPS:0]   valid_ff;
   logic signed [AW-1:0] rounded;

   // left half-plane: turn by a quarter turn toward the right half-plane
   always_ff @(posedge clock) begin
      zero_ff[0] <= (in_x == '0) && (in_y == '0);
      if (in_x[VW-1] && !in_y[VW-1]) begin
         x_ff[0]   <= in_y;
         y_ff[0]   <= -in_x;
         acc_ff[0] <= QUARTER_TURN;
      end else if (in_x[VW-1]) begin
         x_ff[0]   <= -in_y;
         y_ff[0]   <= in_x;
         acc_ff[0] <= -QUARTER_TURN;
      end else begin
         x_ff[0]   <= in_x;
         y_ff[0]   <= in_y;
         acc_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [AW-1:0] ANG = AW'(atan_entry(i));
      vec_type dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;

      always_ff @(posedge clock) begin
         zero_ff[i+1] <= zero_ff[i];
         if (!y_ff[i][VW-1]) begin
            x_ff[i+1]   <= x_ff[i] + dx;
            y_ff[i+1]   <= y_ff[i] - dy;
            acc_ff[i+1] <= acc_ff[i] + ANG;
         end else begin
            x_ff[i+1]   <= x_ff[i] - dx;
            y_ff[i+1]   <= y_ff[i] + dy;
            acc_ff[i+1] <= acc_ff[i] - ANG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[STEPS-1:0], in_valid};
      end
   end

   assign rounded   = (acc_ff[STEPS] + AW'(32768)) >>> 16;
   assign out_valid = valid_ff[STEPS];
   assign out_angle = zero_ff[STEPS] ? '0 : rounded[16:0];

endmodule

@@ rtl/q2e_checker.sv @@
// Port-level checks for quaternion_to_euler_degrees, bound to the top level.
// Uses q2e_pkg for the pipeline latency.
module q2e_checker
   import q2e_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [14:0] rsp_pitch_angle,
   input logic signed [15:0] rsp_yaw_angle,
   input logic signed [15:0] rsp_roll_angle
);

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("response missing at fixed latency");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 15'sd9000 && rsp_pitch_angle >= -15'sd9000))
      else $error("pitch out of range");

   a_yaw_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_yaw_angle <= 16'sd18000 && rsp_yaw_angle >= -16'sd18000
                     && rsp_roll_angle <= 16'sd18000 && rsp_roll_angle >= -16'sd18000))
      else $error("yaw or roll out of range");

endmodule

bind quaternion_to_euler_degrees q2e_checker u_q2e_checker (
   .clock, .reset, .start, .busy, .rsp_valid,
   .rsp_pitch_angle, .rsp_yaw_angle, .rsp_roll_angle
);

@@ sim/quaternion_to_euler_degrees_test.sv @@
// Self-checking testbench for quaternion_to_euler_degrees: drives quaternion
// requests, predicts pitch/yaw/roll with a CORDIC model and checks each result.
// Depends on rtl/q2e_pkg.sv and rtl/quaternion_to_euler_degrees.sv.
module quaternion_to_euler_degrees_test;
   timeunit 1ns;
   timeprecision 1ps;
   import q2e_pkg::*;

   typedef struct {
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic signed [15:0] roll;
   } angles_type;

   int error_count = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic longint floor_shift(input longint v, input int k);
      return v >>> k;
   endfunction

   function automatic longint atan_degrees(input longint yv, input longint xv);
      longint acc, t, dx, dy;
      acc = 0;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
         t = xv;
         if (yv >= 0) begin
            xv = yv; yv = -t; acc = 589824000;
         end else begin
            xv = -yv; yv = t; acc = -589824000;
         end
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = floor_shift(yv, i);
         dy = floor_shift(xv, i);
         if (yv >= 0) begin
            xv += dx; yv -= dy; acc += longint'(atan_entry(i));
         end else begin
            xv -= dx; yv += dy; acc -= longint'(atan_entry(i));
         end
      end
      return floor_shift(acc + 32768, 16);
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint root_floor(input longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b; res = (res >> 1) + b;
         end else res >>= 1;
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic angles_type euler_from_quat(input logic signed [15:0] qw,
         input logic signed [15:0] qx, input logic signed [15:0] qy,
         input logic signed [15:0] qz);
      longint w, x, y, z, s, c;
      longint unsigned s2;
      angles_type a;
      w = qw; x = qx; y = qy; z = qz;
      s = clamp(2 * (w * x - y * z), -(64'sd1 << 28), 64'sd1 << 28);
      s2 = longint'(s < 0 ? -s : s);
      s2 = s2 * s2;
      c = root_floor((64'd1 << 56) - s2);
      a.pitch = 15'(clamp(atan_degrees(s, c), -9000, 9000));
      a.yaw = 16'(clamp(atan_degrees(2 * (w * y + z * x),
                                     (64'sd1 << 28) - 2 * (x * x + y * y)), -18000, 18000));
      a.roll = 16'(clamp(atan_degrees(2 * (w * z + x * y),
                                      (64'sd1 << 28) - 2 * (x * x + z * z)), -18000, 18000));
      return a;
   endfunction

   class angle_scoreboard;
      angles_type pending[$];

      function void note_request(input logic signed [15:0] qw, qx, qy, qz);
         pending.push_back(euler_from_quat(qw, qx, qy, qz));
      endfunction

      task check_result(input logic signed [14:0] p, input logic signed [15:0] yw,
                        input logic signed [15:0] r);
         angles_type e;
         if (pending.size() == 0) begin
            report_mismatch("unexpected result", p, 0);
            return;
         end
         e = pending.pop_front();
         if (p !== e.pitch) report_mismatch("pitch", p, e.pitch);
         if (yw !== e.yaw) report_mismatch("yaw", yw, e.yaw);
         if (r !== e.roll) report_mismatch("roll", r, e.roll);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [15:0] req_quat_w = 0, req_quat_x = 0, req_quat_y = 0, req_quat_z = 0;
   logic rsp_valid;
   logic signed [14:0] rsp_pitch_angle;
   logic signed [15:0] rsp_yaw_angle, rsp_roll_angle;

   angle_scoreboard board = new();

   quaternion_to_euler_degrees DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result(rsp_pitch_angle, rsp_yaw_angle, rsp_roll_angle);
   end

   function automatic logic signed [15:0] random_component();
      case ($urandom_range(0, 9))
         0: return 16'(-16384);
         1: return 16'(16384);
         2: return 16'($urandom());     // any bit pattern, -32768 included
         3: return 16'($urandom_range(0, 8) - 4);
         default: return 16'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // Hold start for one accepted request, then drop it unless another follows.
   task automatic send_request(input logic signed [15:0] qw, qx, qy, qz, input bit keep);
      start <= 1;
      req_quat_w <= qw; req_quat_x <= qx; req_quat_y <= qy; req_quat_z <= qz;
      do @(posedge clock); while (busy);
      board.note_request(qw, qx, qy, qz);
      if (!keep) start <= 0;
   endtask

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) n = 0;
      if (n > 0) begin
         start <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   localparam logic signed [15:0] P1 = 16384, N1 = -16384, MN = -32768, MX = 32767;
   localparam logic signed [15:0] H = 11585; // about 0.7071

   initial begin
      logic signed [15:0] dir[$][4];
      int wait_cycles;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      dir = '{'{P1, 0, 0, 0}, '{N1, 0, 0, 0}, '{0, 0, 0, 0}, '{0, P1, 0, 0},
             '{0, 0, P1, 0}, '{0, 0, 0, P1}, '{H, H, 0, 0}, '{H, -H, 0, 0},
             '{H, 0, H, 0}, '{H, 0, -H, 0}, '{H, 0, 0, H}, '{H, 0, 0, -H},
             '{MN, MN, MN, MN}, '{MX, MX, MX, MX}, '{MN, MX, MX, MN},
             '{0, 0, P1, P1}, '{0, P1, 0, P1}, '{P1, P1, 0, 0}, '{P1, N1, P1, N1},
             '{8192, 8192, 8192, 8192}, '{-1, -1, -1, -1}, '{1, 0, 0, 0},
             '{0, 0, 1, 0}, '{0, 1, 0, 0}};
      // directed requests go back to back
      foreach (dir[i]) send_request(dir[i][0], dir[i][1], dir[i][2], dir[i][3], 1);
      for (int i = 0; i < 1850; i++) begin
         send_request(random_component(), random_component(), random_component(),
                      random_component(), 1);
         idle_gap();
         if (i == 900) begin
            start <= 0;
            while (board.pending.size() != 0) @(posedge clock);
         end
      end
      start <= 0;
      wait_cycles = 0;
      while (board.pending.size() != 0 && wait_cycles < 10 * LATENCY) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY + 5) @(posedge clock);
      if (error_count == 0 && board.pending.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end
endmodule
